[sv/sat_pkg.sv]
// ----------------------------------------------------------------------------
// sat_pkg
// Shared types and codes for the station association table.
// ----------------------------------------------------------------------------
package sat_pkg;

  localparam int MacW   = 48;
  localparam int ReqW   = 2;
  localparam int StatW  = 2;
  localparam int CountW = 6;
  localparam int AidW   = 16;

  // request codes
  localparam logic [ReqW-1:0] REQ_ADD    = 2'd0;
  localparam logic [ReqW-1:0] REQ_AUTH   = 2'd1;
  localparam logic [ReqW-1:0] REQ_REMOVE = 2'd2;

  // status codes
  localparam logic [StatW-1:0] ST_OK        = 2'd0;
  localparam logic [StatW-1:0] ST_FULL      = 2'd1;
  localparam logic [StatW-1:0] ST_NOT_FOUND = 2'd2;

  localparam logic [AidW-1:0] AID_RESET = 16'd1;

  typedef struct packed {
    logic [ReqW-1:0] req_type;
    logic [MacW-1:0] mac_address;
  } sat_req_t;

  typedef struct packed {
    logic [StatW-1:0]  status;
    logic [CountW-1:0] station_count;
  } sat_rsp_t;

  typedef enum logic [0:0] {
    S_IDLE,
    S_EXEC
  } sat_state_t;

  // controller to datapath
  typedef struct packed {
    logic capture;
    logic execute;
  } sat_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic out_hold;
  } sat_stat_t;

endpackage

[sv/sat_ctrl.sv]
// ----------------------------------------------------------------------------
// sat_ctrl
// Request sequencer: accept a word, then run the lookup and update.
// ----------------------------------------------------------------------------
module sat_ctrl
  import sat_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  sat_stat_t stat,
  output sat_cmd_t  cmd
);

  sat_state_t state;
  sat_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) state_next = S_EXEC;
      end
      S_EXEC: begin
        if (!stat.out_hold) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready    = 1'b0;
    cmd.capture = 1'b0;
    cmd.execute = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready    = 1'b1;
        cmd.capture = in_valid;
      end
      S_EXEC: begin
        // wait while the previous result is still unread
        cmd.execute = !stat.out_hold;
      end
      default: ;
    endcase
  end

endmodule

[sv/sat_datapath.sv]
// ----------------------------------------------------------------------------
// sat_datapath
// Entry table with parallel MAC compare, free-slot pick and result register.
// ----------------------------------------------------------------------------
module sat_datapath
  import sat_pkg::*;
#(
  parameter int TABLE_DEPTH = 32
) (
  input  logic      clk,
  input  logic      rst,
  input  sat_req_t  in_data,
  input  sat_cmd_t  cmd,
  output sat_stat_t stat,
  output logic      out_valid,
  input  logic      out_ready,
  output sat_rsp_t  out_data
);

  localparam int CntW = $clog2(TABLE_DEPTH + 1);

  // captured request
  logic [ReqW-1:0] req;
  logic [MacW-1:0] mac;

  // table
  logic [TABLE_DEPTH-1:0] entry_valid;
  logic [TABLE_DEPTH-1:0] entry_authorized;
  logic [MacW-1:0]        entry_mac      [TABLE_DEPTH];
  logic [AidW-1:0]        entry_assoc_id [TABLE_DEPTH];
  logic [AidW-1:0]        next_assoc_id;
  logic [CntW-1:0]        valid_count;

  logic [TABLE_DEPTH-1:0] match;
  logic [TABLE_DEPTH-1:0] free_vec;
  logic [TABLE_DEPTH-1:0] free_oh;
  logic                   hit;
  logic                   full;
  logic                   do_add;
  logic                   do_auth;
  logic                   do_remove;
  logic [StatW-1:0]       status_next;
  logic [CntW-1:0]        count_next;
  logic [CntW+CountW-1:0] count_ext;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req <= in_data.req_type;
      mac <= in_data.mac_address;
    end
  end

  // valid MACs are unique, so match is at most one-hot
  always_comb begin
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      match[i] = entry_valid[i] && (entry_mac[i] == mac);
    end
  end

  assign free_vec = ~entry_valid;
  assign free_oh  = free_vec & (~free_vec + {{(TABLE_DEPTH-1){1'b0}}, 1'b1});
  assign hit      = |match;
  assign full     = ~|free_vec;

  always_comb begin
    do_add      = 1'b0;
    do_auth     = 1'b0;
    do_remove   = 1'b0;
    status_next = ST_OK;
    count_next  = valid_count;
    case (req)
      REQ_ADD: begin
        if (!hit) begin
          if (full) begin
            status_next = ST_FULL;
          end else begin
            do_add     = 1'b1;
            count_next = valid_count + {{(CntW-1){1'b0}}, 1'b1};
          end
        end
      end
      REQ_AUTH: begin
        if (hit) do_auth = 1'b1;
        else     status_next = ST_NOT_FOUND;
      end
      REQ_REMOVE: begin
        if (hit) begin
          do_remove  = 1'b1;
          count_next = valid_count - {{(CntW-1){1'b0}}, 1'b1};
        end else begin
          status_next = ST_NOT_FOUND;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_valid      <= '0;
      entry_authorized <= '0;
      next_assoc_id    <= AID_RESET;
      valid_count      <= '0;
    end else if (cmd.execute) begin
      for (int i = 0; i < TABLE_DEPTH; i++) begin
        if (do_add && free_oh[i]) begin
          entry_valid[i]      <= 1'b1;
          entry_authorized[i] <= 1'b0;
        end
        if (do_auth && match[i]) entry_authorized[i] <= 1'b1;
        if (do_remove && match[i]) entry_valid[i] <= 1'b0;
      end
      if (do_add) next_assoc_id <= next_assoc_id + AidW'(1);
      valid_count <= count_next;
    end
  end

  // payload of new entries, no reset
  always_ff @(posedge clk) begin
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      if (cmd.execute && do_add && free_oh[i]) begin
        entry_mac[i]      <= mac;
        entry_assoc_id[i] <= next_assoc_id;
      end
    end
  end

  // result register
  assign count_ext = {{CountW{1'b0}}, count_next};

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.execute) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.execute) begin
      out_data.status        <= status_next;
      out_data.station_count <= count_ext[CountW-1:0];
    end
  end

  assign stat.out_hold = out_valid && !out_ready;

endmodule

[sv/station_association_table_core.sv]
// ----------------------------------------------------------------------------
// station_association_table_core
// An accepted request is captured, then executed into the result register once
// the previous result is read; no new request is taken until it has executed.
// The lookup compares all entries at once; the update lands in the same cycle.
// Reset (rst, sync, high): clears all valid and authorized marks, count to 0,
// id counter to 1. MAC and id storage keep their contents until written.
// ----------------------------------------------------------------------------
module station_association_table_core
  import sat_pkg::*;
#(
  parameter int TABLE_DEPTH = 32
) (
  input  logic     clk,
  input  logic     rst,
  // request word
  input  logic     in_valid,
  output logic     in_ready,
  input  sat_req_t in_data,
  // result word
  output logic     out_valid,
  input  logic     out_ready,
  output sat_rsp_t out_data
);

  sat_cmd_t  cmd;
  sat_stat_t stat;

  // Controller: idle state takes a request word into the capture register;
  // execute state commits the table update and loads the result register,
  // holding off only while the previous result word is still unread.
  sat_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // Datapath: CAM row of TABLE_DEPTH entries. Hit vector is one-hot at most
  // (adds never duplicate a MAC); the free slot is the lowest clear valid bit,
  // isolated with a two's-complement trick, so no encoder is needed.
  sat_datapath #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .in_data   (in_data),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

[tb/sv/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for station_association_table_core. A directed table
// covers empty, full, present/absent and unused-code cases. Random add /
// authorize / remove traffic then fills and drains the table, with handshake
// idling on both sides, and every result word is checked against a model.
// ----------------------------------------------------------------------------
module testbench;
  import sat_pkg::*;

  localparam int Depth = 32;
  localparam int ItemsPerPhase = 522;
  // the one request code the block has no operation for
  localparam logic [ReqW-1:0] REQ_UNUSED = 2'd3;

  // one row of the directed table; reps > 1 steps the MAC by one per word
  typedef struct packed {
    logic [ReqW-1:0]   req_type;
    logic [MacW-1:0]   mac_address;
    logic [7:0]        reps;
    bit                typed;
    logic [StatW-1:0]  status;
    logic [CountW-1:0] station_count;
  } table_row_t;

  // expected words only where the table state is obvious; the rest come
  // from the predictor
  localparam table_row_t DirTable [25] = '{
    '{REQ_AUTH,   48'h0000_0000_0000, 8'd1,  1'b1, ST_NOT_FOUND, 6'd0},  // empty table
    '{REQ_REMOVE, 48'hFFFF_FFFF_FFFF, 8'd1,  1'b1, ST_NOT_FOUND, 6'd0},
    '{REQ_UNUSED, 48'h1234_5678_9ABC, 8'd1,  1'b1, ST_OK,        6'd0},
    '{REQ_ADD,    48'h0000_0000_0000, 8'd1,  1'b1, ST_OK,        6'd1},
    '{REQ_ADD,    48'hFFFF_FFFF_FFFF, 8'd1,  1'b1, ST_OK,        6'd2},
    '{REQ_ADD,    48'hFFFF_FFFF_FFFF, 8'd1,  1'b1, ST_OK,        6'd2},  // already present
    '{REQ_AUTH,   48'hFFFF_FFFF_FFFF, 8'd1,  1'b1, ST_OK,        6'd2},
    '{REQ_AUTH,   48'hFFFF_FFFF_FFFF, 8'd1,  1'b1, ST_OK,        6'd2},  // already authorized
    '{REQ_AUTH,   48'h8000_0000_0000, 8'd1,  1'b1, ST_NOT_FOUND, 6'd2},  // one bit off
    '{REQ_REMOVE, 48'h0000_0000_0001, 8'd1,  1'b1, ST_NOT_FOUND, 6'd2},
    '{REQ_REMOVE, 48'h0000_0000_0000, 8'd1,  1'b1, ST_OK,        6'd1},
    '{REQ_REMOVE, 48'h0000_0000_0000, 8'd1,  1'b1, ST_NOT_FOUND, 6'd1},
    '{REQ_ADD,    48'h0000_0000_0000, 8'd1,  1'b1, ST_OK,        6'd2},  // reuses slot 0
    '{REQ_UNUSED, 48'hFFFF_FFFF_FFFF, 8'd1,  1'b1, ST_OK,        6'd2},
    '{REQ_ADD,    48'h0200_0000_0000, 8'd30, 1'b0, ST_OK,        6'd0},  // fill up
    '{REQ_ADD,    48'hAAAA_AAAA_AAAA, 8'd1,  1'b1, ST_FULL,      6'd32},
    '{REQ_AUTH,   48'h0200_0000_0010, 8'd1,  1'b0, ST_OK,        6'd0},
    '{REQ_ADD,    48'hFFFF_FFFF_FFFF, 8'd1,  1'b1, ST_OK,        6'd32}, // present, full
    '{REQ_REMOVE, 48'h0200_0000_0005, 8'd1,  1'b1, ST_OK,        6'd31},
    '{REQ_ADD,    48'h5555_5555_5555, 8'd1,  1'b1, ST_OK,        6'd32}, // takes the hole
    '{REQ_ADD,    48'h0200_0000_0005, 8'd1,  1'b1, ST_FULL,      6'd32},
    '{REQ_REMOVE, 48'h0200_0000_0000, 8'd30, 1'b0, ST_OK,        6'd0},  // drain
    '{REQ_REMOVE, 48'h5555_5555_5555, 8'd1,  1'b0, ST_OK,        6'd0},
    '{REQ_AUTH,   48'h0000_0000_0000, 8'd1,  1'b0, ST_OK,        6'd0},
    '{REQ_REMOVE, 48'hFFFF_FFFF_FFFF, 8'd1,  1'b0, ST_OK,        6'd0}
  };

  logic     clk = 1'b0;
  logic     rst;
  logic     in_valid;
  logic     in_ready;
  sat_req_t in_data;
  logic     out_valid;
  logic     out_ready;
  sat_rsp_t out_data;

  // predictor copy of the table
  bit              sta_valid [Depth];
  logic [MacW-1:0] sta_mac   [Depth];
  bit              sta_auth  [Depth];
  logic [AidW-1:0] sta_aid   [Depth];
  logic [AidW-1:0] next_aid = AID_RESET;
  int              sta_count = 0;

  sat_rsp_t pending_results [$];
  sat_rsp_t oldest_result;
  int       mismatch_count = 0;
  int       send_idle_pct;
  int       rcv_idle_pct;
  bit       growing = 1'b1;

  station_association_table_core #(
    .TABLE_DEPTH(Depth)
  ) i_dut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  always #2 clk = ~clk;

  // Runaway guard: well over the slowest legal run at these idle rates.
  initial begin
    #2_000_000;
    $display("testbench: done, errors");
    $finish;
  end

  task automatic flag_mismatch(input string what, input int got, input int want);
    $display("mismatch: %s got %0d want %0d at %0t", what, got, want, $time);
    mismatch_count++;
  endtask

  // Applies one request word to the predictor table and returns the result word.
  // The lowest matching valid entry is the hit, the lowest invalid one the free slot.
  function automatic sat_rsp_t apply_station_request(sat_req_t w);
    sat_rsp_t r;
    int       hit;
    int       slot;
    hit = -1;
    slot = -1;
    for (int i = Depth - 1; i >= 0; i--) begin
      if (sta_valid[i] && sta_mac[i] == w.mac_address) hit = i;
      if (!sta_valid[i]) slot = i;
    end
    r.status = ST_OK;
    case (w.req_type)
      REQ_ADD: begin
        if (hit < 0) begin
          if (slot < 0) begin
            r.status = ST_FULL;
          end else begin
            sta_valid[slot] = 1'b1;
            sta_mac[slot] = w.mac_address;
            sta_aid[slot] = next_aid;
            sta_auth[slot] = 1'b0;
            next_aid = next_aid + 1'b1;
            sta_count++;
          end
        end
      end
      REQ_AUTH: begin
        if (hit < 0) r.status = ST_NOT_FOUND;
        else sta_auth[hit] = 1'b1;
      end
      REQ_REMOVE: begin
        if (hit < 0) begin
          r.status = ST_NOT_FOUND;
        end else begin
          sta_valid[hit] = 1'b0;
          sta_count--;
        end
      end
      default: ;
    endcase
    r.station_count = sta_count[CountW-1:0];
    return r;
  endfunction

  function automatic logic [MacW-1:0] random_mac();
    logic [63:0] v;
    v = {$urandom, $urandom};
    return v[MacW-1:0];
  endfunction

  // MAC of some entry the predictor holds as valid; random if the table is empty
  function automatic logic [MacW-1:0] some_present_mac();
    int idx;
    if (sta_count == 0) return random_mac();
    idx = $urandom_range(Depth - 1);
    while (!sta_valid[idx]) idx = (idx + 1) % Depth;
    return sta_mac[idx];
  endfunction

  // Auth/remove requests mostly name stations that are present, so they hit.
  // Alternates growing and draining so the table reaches full and empty.
  function automatic sat_req_t next_random_request();
    sat_req_t w;
    int       roll;
    int       add_new;
    int       remove_hit;
    if (sta_count == Depth && $urandom_range(7) == 0) growing = 1'b0;
    if (sta_count < 3 && $urandom_range(7) == 0) growing = 1'b1;
    add_new = growing ? 45 : 10;
    remove_hit = growing ? 10 : 45;
    roll = $urandom_range(99);
    w.mac_address = some_present_mac();
    if (roll < add_new) begin
      w.req_type = REQ_ADD;
      w.mac_address = random_mac();
    end else if (roll < add_new + remove_hit) begin
      w.req_type = REQ_REMOVE;
    end else if (roll < 70) begin
      w.req_type = REQ_AUTH;
    end else if (roll < 78) begin
      w.req_type = REQ_ADD;
    end else if (roll < 88) begin
      // near miss: a stored address with one bit flipped
      w.req_type = roll < 81 ? REQ_ADD : roll < 85 ? REQ_AUTH : REQ_REMOVE;
      w.mac_address = w.mac_address ^ (48'd1 << $urandom_range(MacW - 1));
    end else if (roll < 95) begin
      w.req_type = roll < 92 ? REQ_AUTH : REQ_REMOVE;
      w.mac_address = random_mac();
    end else begin
      w.req_type = REQ_UNUSED;
      w.mac_address = random_mac();
    end
    return w;
  endfunction

  // Drives one request word and waits for its accept. Valid stays high
  // between back-to-back words; it only drops during an idle gap.
  task automatic send_word(input sat_req_t w, input bit typed, input sat_rsp_t typed_rsp);
    sat_rsp_t predicted;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= w;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predicted = apply_station_request(w);
    pending_results.push_back(typed ? typed_rsp : predicted);
  endtask

  // Result side: random backpressure, rate set per phase.
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= rcv_idle_pct);
  end

  // Result checker: every accepted word against the oldest expectation.
  always @(posedge clk) begin
    if (!rst && out_valid === 1'b1 && out_ready === 1'b1) begin
      if (pending_results.size() == 0) begin
        flag_mismatch("result word with nothing pending", out_data.status, -1);
      end else begin
        oldest_result = pending_results.pop_front();
        if (out_data.status !== oldest_result.status)
          flag_mismatch("status", out_data.status, oldest_result.status);
        if (out_data.station_count !== oldest_result.station_count)
          flag_mismatch("station_count", out_data.station_count,
                        oldest_result.station_count);
      end
    end
  end

  initial begin
    sat_req_t w;
    sat_rsp_t r;
    rst <= 1'b1;
    in_valid <= 1'b0;
    in_data <= '0;
    out_ready <= 1'b0;
    send_idle_pct = 31;
    rcv_idle_pct = 69;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // directed table
    foreach (DirTable[k]) begin
      for (int n = 0; n < DirTable[k].reps; n++) begin
        w.req_type = DirTable[k].req_type;
        w.mac_address = DirTable[k].mac_address + MacW'(n);
        r.status = DirTable[k].status;
        r.station_count = DirTable[k].station_count;
        send_word(w, DirTable[k].typed, r);
      end
    end

    // random traffic: receiver-heavy idling, then sender-heavy, then none
    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct = phase == 0 ? 31 : phase == 1 ? 69 : 0;
      rcv_idle_pct = phase == 0 ? 69 : phase == 1 ? 31 : 0;
      repeat (ItemsPerPhase) send_word(next_random_request(), 1'b0, '0);
    end
    in_valid <= 1'b0;

    // drain, then keep running to catch any stray result word
    while (pending_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule
